@@ rtl/aoc_pkg.sv @@
// Shared types and constants for the alpha-over compositor.
// No dependencies; every other file imports this package.
package aoc_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned NUM_LANES   = NUM_CH + 1;
  localparam int unsigned PROD_W      = 2 * CH_W;
  localparam int unsigned NUM_W       = 3 * CH_W;
  localparam int unsigned QUOT_W      = CH_W;
  localparam int unsigned QIDX_W      = $clog2(QUOT_W);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CH_W-1:0]   ALPHA_MAX      = 8'd255;
  localparam logic [CH_W-1:0]   COPY_ALPHA_MIN = 8'd253;
  localparam logic [PROD_W-1:0] ZERO_N_MAX     = 16'd650;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SRC_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DST_ALPHA = 2'd1;

  typedef enum logic [1:0] {
    CASE_COPY  = 2'd0,
    CASE_ZERO  = 2'd1,
    CASE_BLEND = 2'd2
  } case_t;

  typedef struct packed {
    logic src_has_alpha;
    logic dst_has_alpha;
  } cfg_t;

  // One classified pixel pair handed from the front to the divide pipeline.
  typedef struct packed {
    case_t                          cls;
    logic [NUM_CH-1:0][CH_W-1:0]    rgb_copy;
    logic [CH_W-1:0]                alpha_copy;
    logic [PROD_W-1:0]              n;
    logic [NUM_CH-1:0][NUM_W-1:0]   m;
  } job_t;

endpackage

@@ rtl/aoc_in_if.sv @@
// Input channel: one source/destination pixel pair per transfer.
// Depends on aoc_pkg for the channel width.
interface aoc_in_if;
  import aoc_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] src_red;
  logic [CH_W-1:0] src_green;
  logic [CH_W-1:0] src_blue;
  logic [CH_W-1:0] src_alpha;
  logic [CH_W-1:0] dst_red;
  logic [CH_W-1:0] dst_green;
  logic [CH_W-1:0] dst_blue;
  logic [CH_W-1:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

@@ rtl/aoc_out_if.sv @@
// Result channel: one composited pixel and its blend case per transfer.
// Depends on aoc_pkg for the channel width.
interface aoc_out_if;
  import aoc_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic [CH_W-1:0] out_alpha;
  logic [1:0]      blend_case;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, blend_case,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, blend_case,
    output ready
  );
endinterface

@@ rtl/aoc_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on aoc_pkg for the index and data widths.
interface aoc_cfg_if;
  import aoc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/alpha_over_compositor.sv @@
// Alpha-over compositor: non-premultiplied source-over blend of RGBA8 pairs.
// Throughput: one pixel pair per cycle while the result channel is not stalled; a
// result passes through front stages 1 and 2, a queue slot, 8 divide stages and
// the output register. The 4-entry queue absorbs stalls.
// Reset (synchronous, rst_n low): pipelines and queue empty, both alpha flags 1.
module alpha_over_compositor (
  input  logic   clk,
  input  logic   rst_n,
  aoc_in_if.sink     in_ch,
  aoc_out_if.source  out_ch,
  aoc_cfg_if.sink    cfg_ch
);
  import aoc_pkg::*;

  logic src_alpha_r;
  logic dst_alpha_r;
  cfg_t cfg;
  logic job_valid;
  logic job_ready;
  job_t job;
  logic q_valid;
  logic q_ready;
  job_t q_job;

  assign cfg_ch.ready      = 1'b1;
  assign cfg.src_has_alpha = src_alpha_r;
  assign cfg.dst_has_alpha = dst_alpha_r;

  // unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_alpha_r <= 1'b1;
      dst_alpha_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDX_SRC_ALPHA: src_alpha_r <= cfg_ch.data[0];
        CFG_IDX_DST_ALPHA: dst_alpha_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  aoc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  aoc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  aoc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/aoc_front.sv @@
// Front end: takes pixel pairs, forms the alpha products, combined alpha and
// color numerators, classifies each pair. Depends on aoc_pkg and aoc_in_if.
module aoc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  aoc_pkg::cfg_t cfg,
  aoc_in_if.sink        in_ch,
  output logic          job_valid,
  input  logic          job_ready,
  output aoc_pkg::job_t job
);
  import aoc_pkg::*;

  // Stage 1: effective alphas and first products
  logic                         f1_v_r;
  logic [NUM_CH-1:0][CH_W-1:0]  f1_s_r;
  logic [CH_W-1:0]              f1_sa_r;
  logic [CH_W-1:0]              f1_da_r;
  logic [CH_W-1:0]              f1_ws_r;
  logic                         f1_dha_r;
  logic [NUM_CH-1:0][PROD_W-1:0] f1_ps_r;
  logic [NUM_CH-1:0][PROD_W-1:0] f1_pd_r;

  // Stage 2: classified job
  logic f2_v_r;
  job_t f2_job_r;

  logic                          adv;
  logic                          acc;
  logic [NUM_CH-1:0][CH_W-1:0]   s_in;
  logic [NUM_CH-1:0][CH_W-1:0]   d_in;
  logic [CH_W-1:0]               sa_nxt;
  logic [CH_W-1:0]               da_nxt;
  logic [NUM_CH-1:0][PROD_W-1:0] ps_nxt;
  logic [NUM_CH-1:0][PROD_W-1:0] pd_nxt;
  logic [PROD_W-1:0]             n_nxt;
  logic [NUM_CH-1:0][NUM_W-1:0]  m_nxt;
  logic [NUM_W-1:0]              mix_prod;
  job_t                          job_nxt;

  assign adv         = !f2_v_r || job_ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;
  assign job_valid   = f2_v_r;
  assign job         = f2_job_r;

  always_comb begin
    s_in   = {in_ch.src_blue, in_ch.src_green, in_ch.src_red};
    d_in   = {in_ch.dst_blue, in_ch.dst_green, in_ch.dst_red};
    sa_nxt = cfg.src_has_alpha ? in_ch.src_alpha : ALPHA_MAX;
    da_nxt = cfg.dst_has_alpha ? in_ch.dst_alpha : ALPHA_MAX;
    for (int j = 0; j < NUM_CH; j++) begin
      ps_nxt[j] = s_in[j] * sa_nxt;
      pd_nxt[j] = d_in[j] * da_nxt;
    end
  end

  always_comb begin
    // N = 255*sa + da*(255-sa); M = 255*s*sa + d*da*(255-sa)
    n_nxt = ({f1_sa_r, {CH_W{1'b0}}} - {{CH_W{1'b0}}, f1_sa_r}) + (f1_da_r * f1_ws_r);
    mix_prod = '0;
    for (int j = 0; j < NUM_CH; j++) begin
      mix_prod = {{CH_W{1'b0}}, f1_pd_r[j]} * {{PROD_W{1'b0}}, f1_ws_r};
      m_nxt[j] = ({f1_ps_r[j], {CH_W{1'b0}}} - {{CH_W{1'b0}}, f1_ps_r[j]}) + mix_prod;
    end
    job_nxt.n          = n_nxt;
    job_nxt.m          = m_nxt;
    job_nxt.rgb_copy   = f1_s_r;
    job_nxt.alpha_copy = f1_dha_r ? f1_sa_r : ALPHA_MAX;
    if (f1_sa_r >= COPY_ALPHA_MIN && f1_da_r >= COPY_ALPHA_MIN) begin
      job_nxt.cls = CASE_COPY;
    end else if (n_nxt <= ZERO_N_MAX) begin
      job_nxt.cls = CASE_ZERO;
    end else begin
      job_nxt.cls = CASE_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= acc;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_s_r   <= s_in;
      f1_sa_r  <= sa_nxt;
      f1_da_r  <= da_nxt;
      f1_ws_r  <= ALPHA_MAX - sa_nxt;
      f1_dha_r <= cfg.dst_has_alpha;
      f1_ps_r  <= ps_nxt;
      f1_pd_r  <= pd_nxt;
      f2_job_r <= job_nxt;
    end
  end

  // hold the classified job while the queue is full
  a_front_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r && !job_ready |=> f2_v_r && $stable(f2_job_r))
    else $error("front job changed while stalled");

endmodule

@@ rtl/aoc_queue.sv @@
// Short job queue between the front end and the divide pipeline.
// Depends on aoc_pkg for the job type and depth.
module aoc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  aoc_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output aoc_pkg::job_t pop_job
);
  import aoc_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/aoc_back.sv @@
// Back end: pipelined restoring divide, one quotient bit per stage for the three
// color lanes, alpha by reciprocal multiply, then result select into the output
// register. Depends on aoc_pkg and aoc_out_if.
module aoc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  aoc_pkg::job_t job,
  aoc_out_if.source     out_ch
);
  import aoc_pkg::*;

  localparam int unsigned NUM_STG = QUOT_W;
  // floor(N / 255) == (N * 0x8081) >> 23 for every 16-bit N
  localparam logic [PROD_W-1:0] ALPHA_RECIP       = 16'h8081;
  localparam int unsigned       ALPHA_RECIP_SHIFT = 23;

  typedef struct packed {
    case_t                           cls;
    logic [NUM_CH-1:0][CH_W-1:0]     rgb_copy;
    logic [CH_W-1:0]                 alpha_copy;
    logic [PROD_W-1:0]               n;
    logic [NUM_CH-1:0][NUM_W-1:0]    rem;
    logic [NUM_LANES-1:0][QUOT_W-1:0] q;
  } bk_t;

  // One quotient bit for each color lane; the alpha quotient rides along.
  function automatic bk_t div_step(bk_t x, logic [QIDX_W-1:0] b);
    bk_t              y;
    logic [NUM_W-1:0] den;
    y = x;
    for (int j = 0; j < NUM_CH; j++) begin
      den = {{CH_W{1'b0}}, x.n} << b;
      if (x.rem[j] >= den) begin
        y.rem[j]  = x.rem[j] - den;
        y.q[j][b] = 1'b1;
      end
    end
    return y;
  endfunction

  logic                        en;
  bk_t                         init;
  logic [2*PROD_W-1:0]         alpha_prod;
  bk_t                         st_r   [NUM_STG];
  bk_t                         st_nxt [NUM_STG];
  logic [NUM_STG-1:0]          st_v_r;
  bk_t                         last;
  logic                        out_v_r;
  logic [NUM_CH-1:0][CH_W-1:0] rgb_nxt;
  logic [CH_W-1:0]             alpha_nxt;
  logic [NUM_CH-1:0][CH_W-1:0] rgb_r;
  logic [CH_W-1:0]             alpha_r;
  case_t                       case_r;

  assign en        = !out_v_r || out_ch.ready;
  assign job_ready = en;
  assign last      = st_r[NUM_STG-1];

  always_comb begin
    alpha_prod      = job.n * ALPHA_RECIP;
    init.cls        = job.cls;
    init.rgb_copy   = job.rgb_copy;
    init.alpha_copy = job.alpha_copy;
    init.n          = job.n;
    init.q          = '0;
    for (int j = 0; j < NUM_CH; j++) begin
      init.rem[j] = job.m[j];
    end
    init.q[NUM_CH] = alpha_prod[ALPHA_RECIP_SHIFT +: QUOT_W];
    st_nxt[0] = div_step(init, QIDX_W'(QUOT_W - 1));
    for (int k = 1; k < NUM_STG; k++) begin
      st_nxt[k] = div_step(st_r[k-1], QIDX_W'(QUOT_W - 1 - k));
    end
  end

  always_comb begin
    case (last.cls)
      CASE_COPY: begin
        rgb_nxt   = last.rgb_copy;
        alpha_nxt = last.alpha_copy;
      end
      CASE_ZERO: begin
        rgb_nxt   = '0;
        alpha_nxt = '0;
      end
      CASE_BLEND: begin
        for (int j = 0; j < NUM_CH; j++) begin
          rgb_nxt[j] = last.q[j];
        end
        alpha_nxt = last.q[NUM_CH];
      end
      default: begin
        rgb_nxt   = '0;
        alpha_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      st_v_r  <= {st_v_r[NUM_STG-2:0], job_valid};
      out_v_r <= st_v_r[NUM_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_STG; k++) begin
        st_r[k] <= st_nxt[k];
      end
      rgb_r   <= rgb_nxt;
      alpha_r <= alpha_nxt;
      case_r  <= last.cls;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_red    = rgb_r[0];
  assign out_ch.out_green  = rgb_r[1];
  assign out_ch.out_blue   = rgb_r[2];
  assign out_ch.out_alpha  = alpha_r;
  assign out_ch.blend_case = case_r;

  a_back_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && case_r == CASE_ZERO |-> rgb_r == '0 && alpha_r == '0)
    else $error("transparent result not zero");

  a_back_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(st_v_r))
    else $error("divide pipeline moved while stalled");

  a_back_copy_case: assert property (@(posedge clk) disable iff (!rst_n)
    en && st_v_r[NUM_STG-1] |=> out_v_r && case_r == $past(last.cls))
    else $error("result case lost in output register");

endmodule

@@ tb/sv/alpha_over_compositor_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for alpha_over_compositor: directed pixel pairs, then
// random pairs under every alpha-flag setting and several idle/stall mixes.
// Depends on aoc_pkg and the aoc_in_if, aoc_out_if and aoc_cfg_if interfaces.
module alpha_over_compositor_test;
  import aoc_pkg::*;

  localparam int unsigned FULL          = ALPHA_MAX;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          LONG_HOLD     = 80;
  localparam int          SEG_ITEMS     = 90;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] src_red, src_green, src_blue, src_alpha;
    logic [CH_W-1:0] dst_red, dst_green, dst_blue, dst_alpha;
  } pixel_pair_t;

  typedef struct packed {
    logic [CH_W-1:0] red, green, blue, alpha;
    case_t           blend_case;
  } composite_t;

  typedef struct packed {
    logic        src_flag;
    logic        dst_flag;
    pixel_pair_t pair;
    logic        typed;
    composite_t  want;
  } vector_t;

  logic clk;
  logic rst_n;

  aoc_in_if  in_ch();
  aoc_out_if out_ch();
  aoc_cfg_if cfg_ch();

  alpha_over_compositor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  composite_t  composites_due[$];
  vector_t     vectors[$];
  logic        src_alpha_on = 1'b1;
  logic        dst_alpha_on = 1'b1;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          holds_asked = 0;
  int          bad_results = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CH_W-1:0] mix_channel(input int unsigned s, d, sa, da, n);
    int unsigned q;
    q = (FULL * s * sa + d * da * (FULL - sa)) / n;
    return (q > FULL) ? ALPHA_MAX : q[CH_W-1:0];
  endfunction

  function automatic composite_t composite_over(input pixel_pair_t p,
                                                input logic src_flag, dst_flag);
    composite_t  r;
    int unsigned sa, da, n, a;
    sa = src_flag ? p.src_alpha : FULL;
    da = dst_flag ? p.dst_alpha : FULL;
    n  = FULL * sa + da * (FULL - sa);
    r  = '0;
    if (sa >= COPY_ALPHA_MIN && da >= COPY_ALPHA_MIN) begin
      r.red        = p.src_red;
      r.green      = p.src_green;
      r.blue       = p.src_blue;
      r.alpha      = dst_flag ? sa[CH_W-1:0] : ALPHA_MAX;
      r.blend_case = CASE_COPY;
    end else if (n <= ZERO_N_MAX) begin
      r.blend_case = CASE_ZERO;
    end else begin
      r.red   = mix_channel(p.src_red, p.dst_red, sa, da, n);
      r.green = mix_channel(p.src_green, p.dst_green, sa, da, n);
      r.blue  = mix_channel(p.src_blue, p.dst_blue, sa, da, n);
      a = n / FULL;
      r.alpha = (!dst_flag || a > FULL) ? ALPHA_MAX : a[CH_W-1:0];
      r.blend_case = CASE_BLEND;
    end
    return r;
  endfunction

  function automatic logic [31:0] rgba(input logic [CH_W-1:0] r, g, b, a);
    return {r, g, b, a};
  endfunction

  // Lean on the copy and zero thresholds, with plenty of plain random too.
  function automatic logic [CH_W-1:0] pick_alpha();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return ALPHA_MAX;
      2:       return 8'(250 + $urandom_range(5));
      3:       return 8'($urandom_range(4));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return ALPHA_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    p.src_red   = pick_level();
    p.src_green = pick_level();
    p.src_blue  = pick_level();
    p.src_alpha = pick_alpha();
    p.dst_red   = pick_level();
    p.dst_green = pick_level();
    p.dst_blue  = pick_level();
    p.dst_alpha = pick_alpha();
    return p;
  endfunction

  task automatic add_row(input logic sf, df, input logic [31:0] src, dst,
                         input logic typed, input logic [31:0] want, input case_t c);
    vector_t v;
    v.src_flag = sf;
    v.dst_flag = df;
    v.pair     = {src, dst};
    v.typed    = typed;
    v.want     = {want, c};
    vectors.push_back(v);
  endtask

  // Offer one pair; on transfer, queue what it must produce.
  task automatic offer_pair(input pixel_pair_t p, input logic typed, input composite_t want);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.src_red   <= p.src_red;
    in_ch.src_green <= p.src_green;
    in_ch.src_blue  <= p.src_blue;
    in_ch.src_alpha <= p.src_alpha;
    in_ch.dst_red   <= p.dst_red;
    in_ch.dst_green <= p.dst_green;
    in_ch.dst_blue  <= p.dst_blue;
    in_ch.dst_alpha <= p.dst_alpha;
    do @(posedge clk); while (!in_ch.ready);
    composites_due.push_back(typed ? want : composite_over(p, src_alpha_on, dst_alpha_on));
  endtask

  task automatic quiesce(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (composites_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_IDX_SRC_ALPHA)
      src_alpha_on = val[0];
    else if (idx == CFG_IDX_DST_ALPHA)
      dst_alpha_on = val[0];
  endtask

  // Drain, then write both flags with junk in the upper data bits, then write an unused index.
  task automatic set_flags(input logic src_flag, dst_flag);
    logic [CFG_DATA_W-1:0] d;
    quiesce(SETTLE_CYCLES);
    d = CFG_DATA_W'($urandom);
    d[0] = src_flag;
    write_reg(CFG_IDX_SRC_ALPHA, d);
    d = CFG_DATA_W'($urandom);
    d[0] = dst_flag;
    write_reg(CFG_IDX_DST_ALPHA, d);
    write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: random stalls, plus a long hold-off when asked.
  initial begin
    int holds_seen;
    int hold_left;
    holds_seen = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    composite_t got;
    composite_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.red        = out_ch.out_red;
      got.green      = out_ch.out_green;
      got.blue       = out_ch.out_blue;
      got.alpha      = out_ch.out_alpha;
      got.blend_case = case_t'(out_ch.blend_case);
      if (composites_due.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d case=%0d", $realtime,
                   got.red, got.green, got.blue, got.alpha, got.blend_case);
      end else begin
        want = composites_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.blend_case !== want.blend_case) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d a=%0d case=%0d, got r=%0d g=%0d b=%0d a=%0d case=%0d",
                     $realtime, want.red, want.green, want.blue, want.alpha, want.blend_case,
                     got.red, got.green, got.blue, got.alpha, got.blend_case);
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.src_red   <= '0;
    in_ch.src_green <= '0;
    in_ch.src_blue  <= '0;
    in_ch.src_alpha <= '0;
    in_ch.dst_red   <= '0;
    in_ch.dst_green <= '0;
    in_ch.dst_blue  <= '0;
    in_ch.dst_alpha <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;

    // Reset flags first: both alphas live.
    add_row(1, 1, rgba(10, 20, 30, 255), rgba(40, 50, 60, 255), 1, rgba(10, 20, 30, 255), CASE_COPY);
    add_row(1, 1, rgba(255, 255, 255, 0), rgba(255, 255, 255, 0), 1, '0, CASE_ZERO);
    add_row(1, 1, rgba(200, 100, 50, 0), rgba(1, 2, 3, 255), 1, rgba(1, 2, 3, 255), CASE_BLEND);
    add_row(1, 1, rgba(7, 8, 9, 255), rgba(90, 91, 92, 0), 1, rgba(7, 8, 9, 255), CASE_BLEND);
    add_row(1, 1, rgba(11, 22, 33, 253), rgba(0, 0, 0, 253), 1, rgba(11, 22, 33, 253), CASE_COPY);
    add_row(1, 1, rgba(11, 22, 33, 252), rgba(44, 55, 66, 253), 0, '0, CASE_BLEND);
    add_row(1, 1, rgba(11, 22, 33, 253), rgba(44, 55, 66, 252), 0, '0, CASE_BLEND);
    add_row(1, 1, rgba(255, 255, 255, 2), rgba(255, 255, 255, 0), 1, '0, CASE_ZERO);
    add_row(1, 1, rgba(255, 255, 255, 1), rgba(255, 255, 255, 1), 1, '0, CASE_ZERO);
    add_row(1, 1, rgba(100, 150, 250, 3), rgba(9, 9, 9, 0), 1, rgba(100, 150, 250, 3), CASE_BLEND);
    add_row(1, 1, rgba(9, 9, 9, 0), rgba(100, 150, 250, 3), 1, rgba(100, 150, 250, 3), CASE_BLEND);
    add_row(1, 1, rgba(255, 0, 128, 2), rgba(0, 255, 127, 1), 0, '0, CASE_BLEND);
    add_row(1, 1, rgba(255, 255, 255, 128), rgba(255, 255, 255, 128), 0, '0, CASE_BLEND);
    add_row(1, 1, rgba(0, 0, 0, 255), rgba(255, 255, 255, 255), 1, rgba(0, 0, 0, 255), CASE_COPY);
    add_row(1, 1, rgba(255, 255, 255, 255), rgba(0, 0, 0, 255), 1, rgba(255, 255, 255, 255), CASE_COPY);
    // Source without alpha: treated as opaque.
    add_row(0, 1, rgba(1, 2, 3, 0), rgba(4, 5, 6, 255), 1, rgba(1, 2, 3, 255), CASE_COPY);
    add_row(0, 1, rgba(1, 2, 3, 0), rgba(4, 5, 6, 0), 1, rgba(1, 2, 3, 255), CASE_BLEND);
    add_row(0, 1, rgba(50, 60, 70, 17), rgba(4, 5, 6, 100), 1, rgba(50, 60, 70, 255), CASE_BLEND);
    // Destination without alpha: output alpha pinned to full.
    add_row(1, 0, rgba(1, 2, 3, 0), rgba(4, 5, 6, 0), 1, rgba(4, 5, 6, 255), CASE_BLEND);
    add_row(1, 0, rgba(1, 2, 3, 254), rgba(4, 5, 6, 0), 1, rgba(1, 2, 3, 255), CASE_COPY);
    add_row(1, 0, rgba(200, 100, 0, 77), rgba(0, 100, 200, 9), 0, '0, CASE_BLEND);
    add_row(0, 0, rgba(33, 44, 55, 0), rgba(66, 77, 88, 0), 1, rgba(33, 44, 55, 255), CASE_COPY);
    add_row(0, 0, rgba(255, 255, 255, 0), rgba(0, 0, 0, 0), 1, rgba(255, 255, 255, 255), CASE_COPY);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].src_flag !== src_alpha_on || vectors[i].dst_flag !== dst_alpha_on)
        set_flags(vectors[i].src_flag, vectors[i].dst_flag);
      offer_pair(vectors[i].pair, vectors[i].typed, vectors[i].want);
    end

    for (int mode = 0; mode < 4; mode++) begin
      for (int k = 0; k < 4; k++) begin
        set_flags(!k[0], !k[1]);
        case (mode)
          0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1:       begin src_idle_pct = 53; sink_stall_pct = 0;  end
          2:       begin src_idle_pct = 0;  sink_stall_pct = 53; end
          default: begin src_idle_pct = 30; sink_stall_pct = 30; end
        endcase
        for (int j = 0; j < SEG_ITEMS; j++) begin
          // Back up the pipe against a long sink hold-off, then let it drain fully.
          if (mode == 0 && k == 0 && j == 30)
            holds_asked++;
          if (mode == 0 && k == 0 && j == 70)
            quiesce(0);
          offer_pair(random_pair(), 1'b0, '0);
        end
      end
    end

    quiesce(SETTLE_CYCLES);
    if (bad_results == 0 && composites_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
